// File: rtl/mbbgc_pkg.sv
// Shared types and constants for the mappable-base GC binner.
package mbbgc_pkg;

	localparam int unsigned CNT_W   = 21;
	localparam int unsigned COV_W   = 28;
	localparam int unsigned POS_W   = 32;
	localparam int unsigned PCT_W   = 7;
	localparam int unsigned STEP_W  = 3;
	localparam int unsigned QDEPTH  = 4;
	localparam int unsigned QPTR_W  = 2;
	localparam int unsigned QCNT_W  = 3;

	localparam logic [COV_W-1:0] COV_MAX     = {COV_W{1'b1}};
	localparam logic [COV_W-1:0] PCT_SCALE   = COV_W'(100);
	localparam logic [CNT_W-1:0] BIN_SIZE_RST = CNT_W'(100);
	localparam logic [STEP_W-1:0] STEP_TOP   = STEP_W'(PCT_W - 1);

	localparam logic [7:0] CH_A_UP = 8'h41;
	localparam logic [7:0] CH_C_UP = 8'h43;
	localparam logic [7:0] CH_G_UP = 8'h47;
	localparam logic [7:0] CH_T_UP = 8'h54;
	localparam logic [7:0] CH_A_LO = 8'h61;
	localparam logic [7:0] CH_C_LO = 8'h63;
	localparam logic [7:0] CH_G_LO = 8'h67;
	localparam logic [7:0] CH_T_LO = 8'h74;

	typedef struct packed {
		logic [POS_W-1:0] bin_start;
		logic [POS_W-1:0] bin_end;
		logic [COV_W-1:0] coverage_sum;
		logic [CNT_W-1:0] mappable_count;
		logic [CNT_W-1:0] gc_count;
		logic [CNT_W-1:0] acgt_count;
		logic             is_partial;
	} bin_rec_t;

endpackage

// File: rtl/mbbgc_front.sv
// Front end: accepts bases, keeps the running bin and pushes closed bins.
module mbbgc_front #(
	parameter int unsigned MAX_BIN_SIZE  = 1048576,
	parameter int unsigned POSITION_BITS = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            accept,
	input  logic                            is_mappable,
	input  logic [7:0]                      coverage,
	input  logic [7:0]                      base_code,
	input  logic                            last_of_sequence,
	input  logic                            bin_size_wr_en,
	input  logic [mbbgc_pkg::CNT_W-1:0]     bin_size,
	output logic                            push,
	output mbbgc_pkg::bin_rec_t             push_rec
);

	logic [POSITION_BITS-1:0]          pos_q;
	logic [POSITION_BITS-1:0]          start_q;
	logic [POSITION_BITS-1:0]          end_pos;
	logic [mbbgc_pkg::CNT_W-1:0]       bin_size_q;
	logic [mbbgc_pkg::CNT_W-1:0]       eff_size;
	logic [mbbgc_pkg::CNT_W-1:0]       cnt_q, cnt_n;
	logic [mbbgc_pkg::CNT_W-1:0]       gc_q, gc_n;
	logic [mbbgc_pkg::CNT_W-1:0]       acgt_q, acgt_n;
	logic [mbbgc_pkg::COV_W-1:0]       cov_q, cov_n;
	logic [mbbgc_pkg::COV_W:0]         cov_add;
	logic                              is_at, is_gc;
	logic                              bin_full, bin_part;

	always_comb begin
		if (bin_size_q == '0) begin
			eff_size = mbbgc_pkg::CNT_W'(1);
		end else if (32'(bin_size_q) > 32'(MAX_BIN_SIZE)) begin
			eff_size = mbbgc_pkg::CNT_W'(MAX_BIN_SIZE);
		end else begin
			eff_size = bin_size_q;
		end
	end

	assign is_at = (base_code == mbbgc_pkg::CH_A_UP) || (base_code == mbbgc_pkg::CH_A_LO) ||
		(base_code == mbbgc_pkg::CH_T_UP) || (base_code == mbbgc_pkg::CH_T_LO);
	assign is_gc = (base_code == mbbgc_pkg::CH_C_UP) || (base_code == mbbgc_pkg::CH_C_LO) ||
		(base_code == mbbgc_pkg::CH_G_UP) || (base_code == mbbgc_pkg::CH_G_LO);

	assign cov_add = {1'b0, cov_q} + (mbbgc_pkg::COV_W+1)'(coverage);
	assign end_pos = pos_q + POSITION_BITS'(1);

	always_comb begin
		cnt_n  = cnt_q;
		gc_n   = gc_q;
		acgt_n = acgt_q;
		cov_n  = cov_q;
		if (is_mappable) begin
			// saturate the coverage sum
			cov_n = cov_add[mbbgc_pkg::COV_W] ? mbbgc_pkg::COV_MAX
				: cov_add[mbbgc_pkg::COV_W-1:0];
			cnt_n = cnt_q + mbbgc_pkg::CNT_W'(1);
			if (is_at || is_gc) begin
				acgt_n = acgt_q + mbbgc_pkg::CNT_W'(1);
			end
			if (is_gc) begin
				gc_n = gc_q + mbbgc_pkg::CNT_W'(1);
			end
		end
	end

	assign bin_full = (cnt_n == eff_size);
	assign bin_part = !bin_full && last_of_sequence && (cnt_n != '0);
	assign push     = accept && (bin_full || bin_part);

	always_comb begin
		push_rec.bin_start      = mbbgc_pkg::POS_W'(start_q);
		push_rec.bin_end        = mbbgc_pkg::POS_W'(end_pos);
		push_rec.coverage_sum   = cov_n;
		push_rec.mappable_count = cnt_n;
		push_rec.gc_count       = gc_n;
		push_rec.acgt_count     = acgt_n;
		push_rec.is_partial     = bin_part;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_size_q <= mbbgc_pkg::BIN_SIZE_RST;
		end else if (bin_size_wr_en) begin
			bin_size_q <= bin_size;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			start_q <= '0;
			cnt_q   <= '0;
			gc_q    <= '0;
			acgt_q  <= '0;
			cov_q   <= '0;
		end else if (accept) begin
			if (last_of_sequence) begin
				// restart the sequence
				pos_q   <= '0;
				start_q <= '0;
				cnt_q   <= '0;
				gc_q    <= '0;
				acgt_q  <= '0;
				cov_q   <= '0;
			end else if (bin_full) begin
				pos_q   <= end_pos;
				start_q <= end_pos;
				cnt_q   <= '0;
				gc_q    <= '0;
				acgt_q  <= '0;
				cov_q   <= '0;
			end else begin
				pos_q  <= end_pos;
				cnt_q  <= cnt_n;
				gc_q   <= gc_n;
				acgt_q <= acgt_n;
				cov_q  <= cov_n;
			end
		end
	end

endmodule

// File: rtl/mbbgc_queue.sv
// Short queue of closed bins between the front and back ends.
module mbbgc_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  mbbgc_pkg::bin_rec_t  push_rec,
	output logic                 full,
	input  logic                 pop,
	output logic                 not_empty,
	output mbbgc_pkg::bin_rec_t  pop_rec
);

	mbbgc_pkg::bin_rec_t              mem_q [mbbgc_pkg::QDEPTH];
	logic [mbbgc_pkg::QPTR_W-1:0]     wr_ptr_q, rd_ptr_q;
	logic [mbbgc_pkg::QCNT_W-1:0]     count_q;

	assign full      = (count_q == mbbgc_pkg::QCNT_W'(mbbgc_pkg::QDEPTH));
	assign not_empty = (count_q != '0);
	assign pop_rec   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + mbbgc_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + mbbgc_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + mbbgc_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - mbbgc_pkg::QCNT_W'(1);
			end
		end
	end

endmodule

// File: rtl/mbbgc_back.sv
// Back end: computes GC percent with a bit-serial divider and drives results.
module mbbgc_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_not_empty,
	input  mbbgc_pkg::bin_rec_t           q_rec,
	output logic                          q_pop,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [mbbgc_pkg::POS_W-1:0]   bin_start,
	output logic [mbbgc_pkg::POS_W-1:0]   bin_end,
	output logic [mbbgc_pkg::COV_W-1:0]   coverage_sum,
	output logic [mbbgc_pkg::CNT_W-1:0]   mappable_count,
	output logic [mbbgc_pkg::PCT_W-1:0]   gc_percent,
	output logic                          no_acgt,
	output logic                          is_partial
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_MUL  = 4'b0010,
		S_DIV  = 4'b0100,
		S_WAIT = 4'b1000
	} state_t;

	state_t                            state_q;
	mbbgc_pkg::bin_rec_t               rec_q;
	logic [mbbgc_pkg::COV_W-1:0]       rem_q;
	logic [mbbgc_pkg::COV_W-1:0]       dshift;
	logic [mbbgc_pkg::PCT_W-1:0]       quo_q;
	logic [mbbgc_pkg::STEP_W-1:0]      step_q;
	logic                              out_free;
	logic                              load_out;
	logic                              none;

	assign out_free = !out_valid || !out_stall;
	assign load_out = (state_q == S_WAIT) && out_free;
	assign q_pop    = (state_q == S_IDLE) && q_not_empty;
	assign dshift   = mbbgc_pkg::COV_W'(rec_q.acgt_count) << step_q;
	assign none     = (rec_q.acgt_count == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: if (q_not_empty) state_q <= S_MUL;
				S_MUL:  state_q <= S_DIV;
				S_DIV:  if (step_q == '0) state_q <= S_WAIT;
				S_WAIT: if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (q_not_empty) begin
					rec_q <= q_rec;
				end
			end
			S_MUL: begin
				rem_q  <= mbbgc_pkg::COV_W'(rec_q.gc_count) * mbbgc_pkg::PCT_SCALE;
				quo_q  <= '0;
				step_q <= mbbgc_pkg::STEP_TOP;
			end
			S_DIV: begin
				// one quotient bit per cycle, restoring
				if (rem_q >= dshift) begin
					rem_q         <= rem_q - dshift;
					quo_q[step_q] <= 1'b1;
				end
				if (step_q != '0) begin
					step_q <= step_q - mbbgc_pkg::STEP_W'(1);
				end
			end
			S_WAIT: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			bin_start      <= rec_q.bin_start;
			bin_end        <= rec_q.bin_end;
			coverage_sum   <= rec_q.coverage_sum;
			mappable_count <= rec_q.mappable_count;
			gc_percent     <= none ? '0 : quo_q;
			no_acgt        <= none;
			is_partial     <= rec_q.is_partial;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load_out) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

endmodule

// File: rtl/mappable_base_binner_gc.sv
// A closing bin passes the bin queue and the back end's idle, multiply, divide and wait
// states to the output registers. Throughput: one base per cycle while the 4-entry bin
// queue has room; the back end, with a 7-step bit-serial GC percent divider, takes a
// new bin only after its wait state. With bin_size 1 each mappable base closes a bin.
// Reset (arst_n low, asynchronous): position and bin counters clear, queue empties,
// bin_size returns to 100, out_valid drops.
module mappable_base_binner_gc #(
	parameter int unsigned MAX_BIN_SIZE  = 1048576,
	parameter int unsigned POSITION_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          is_mappable,
	input  logic [7:0]                    coverage,
	input  logic [7:0]                    base_code,
	input  logic                          last_of_sequence,
	input  logic                          bin_size_wr_en,
	input  logic [mbbgc_pkg::CNT_W-1:0]   bin_size,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [mbbgc_pkg::POS_W-1:0]   bin_start,
	output logic [mbbgc_pkg::POS_W-1:0]   bin_end,
	output logic [mbbgc_pkg::COV_W-1:0]   coverage_sum,
	output logic [mbbgc_pkg::CNT_W-1:0]   mappable_count,
	output logic [mbbgc_pkg::PCT_W-1:0]   gc_percent,
	output logic                          no_acgt,
	output logic                          is_partial
);

	logic                 accept;
	logic                 push;
	logic                 q_full;
	logic                 q_not_empty;
	logic                 q_pop;
	mbbgc_pkg::bin_rec_t  push_rec;
	mbbgc_pkg::bin_rec_t  pop_rec;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	mbbgc_front #(
		.MAX_BIN_SIZE  (MAX_BIN_SIZE),
		.POSITION_BITS (POSITION_BITS)
	) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.accept           (accept),
		.is_mappable      (is_mappable),
		.coverage         (coverage),
		.base_code        (base_code),
		.last_of_sequence (last_of_sequence),
		.bin_size_wr_en   (bin_size_wr_en),
		.bin_size         (bin_size),
		.push             (push),
		.push_rec         (push_rec)
	);

	mbbgc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_rec  (push_rec),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.pop_rec   (pop_rec)
	);

	mbbgc_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_not_empty    (q_not_empty),
		.q_rec          (pop_rec),
		.q_pop          (q_pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.bin_start      (bin_start),
		.bin_end        (bin_end),
		.coverage_sum   (coverage_sum),
		.mappable_count (mappable_count),
		.gc_percent     (gc_percent),
		.no_acgt        (no_acgt),
		.is_partial     (is_partial)
	);

endmodule
